@@ src/gda_pkg.sv @@
package gda_pkg;

  localparam int COUNT_BITS_DEFAULT = 22;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int SERIAL_W = 22;
  localparam int DIFF_W   = 23;
  localparam int CHUNK_YW = 9;
  localparam int CHUNK_DW = 18;

  localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;
  localparam logic [SERIAL_W-1:0] SERIAL_MAX = 22'd3652058;

  typedef enum logic [1:0] {
    FUNC_ADD,
    FUNC_SUB,
    FUNC_DIFF,
    FUNC_NONE
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TO_YEARS,
    ST_TO_MONTHS,
    ST_TO_DONE,
    ST_OFFSET,
    ST_FROM_YEARS,
    ST_FROM_MONTHS,
    ST_OUT
  } state_t;

  // year blocks: 400, 100, 4 and 1 years
  function automatic logic [CHUNK_YW-1:0] chunk_years(input logic [1:0] phase);
    case (phase)
      2'd0:    chunk_years = 9'd400;
      2'd1:    chunk_years = 9'd100;
      2'd2:    chunk_years = 9'd4;
      default: chunk_years = 9'd1;
    endcase
  endfunction

  // days in each year block
  function automatic logic [CHUNK_DW-1:0] chunk_days(input logic [1:0] phase);
    case (phase)
      2'd0:    chunk_days = 18'd146097;
      2'd1:    chunk_days = 18'd36524;
      2'd2:    chunk_days = 18'd1461;
      default: chunk_days = 18'd365;
    endcase
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      4'd2:                    month_len = leap ? 5'd29 : 5'd28;
      default:                 month_len = 5'd31;
    endcase
  endfunction

endpackage

@@ src/gregorian_date_arithmetic_unit.sv @@
// channel  | direction | fields (tdata from bit 0 up)
// s_axis   | in        | func, first_day/month/year, second_day/month/year, day_count
// m_axis   | out       | result_day/month/year, day_difference, is_before, is_equal,
//          |           | is_after, error
//
// one request at a time; a sequencer drives one year-block/month adder and compare
// a date-to-day-number pass works through year blocks of 400/100/4/1, then months;
// add and subtract run one such pass and the reverse pass, difference runs two
// forward passes; a rejected request skips the remaining passes
// s_axis_tready is high only while idle; a finished result waits in the output
// register under m_axis_tready backpressure while the next request is taken
// rst clears the sequencer and the output valid

module gregorian_date_arithmetic_unit #(
  parameter int COUNT_BITS = gda_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // func[1:0], first_day[6:2], first_month[10:7], first_year[24:11],
  // second_day[29:25], second_month[33:30], second_year[47:34], day_count from 48 up
  input  logic [((48+COUNT_BITS+7)/8)*8-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_day[4:0], result_month[8:5], result_year[22:9], day_difference[45:23],
  // is_before[46], is_equal[47], is_after[48], error[49]
  output logic [55:0]                         m_axis_tdata
);

  localparam int SUM_W = ((COUNT_BITS > gda_pkg::SERIAL_W) ? COUNT_BITS
                                                           : gda_pkg::SERIAL_W) + 1;

  gda_pkg::state_t state, state_next;

  gda_pkg::func_t              func, func_next;
  logic [gda_pkg::DAY_W-1:0]   d1, d1_next, d2, d2_next;
  logic [gda_pkg::MONTH_W-1:0] m1, m1_next, m2, m2_next;
  logic [gda_pkg::YEAR_W-1:0]  y1, y1_next, y2, y2_next;
  logic [COUNT_BITS-1:0]       count, count_next;
  logic                        earlier, earlier_next, equal, equal_next;
  logic                        which, which_next;

  logic [gda_pkg::YEAR_W-1:0]   yrs, yrs_next;
  logic [gda_pkg::SERIAL_W-1:0] days, days_next, s1, s1_next;
  logic [1:0]                   phase, phase_next;
  logic [1:0]                   nb, nb_next, nd, nd_next;
  logic [4:0]                   nc, nc_next;
  logic [gda_pkg::MONTH_W-1:0]  k, k_next;

  logic [gda_pkg::DAY_W-1:0]   res_d, res_d_next;
  logic [gda_pkg::MONTH_W-1:0] res_m, res_m_next;
  logic [gda_pkg::YEAR_W-1:0]  res_y, res_y_next;
  logic [gda_pkg::DIFF_W-1:0]  diff, diff_next;
  logic                        err, err_next;

  logic        out_valid_next;
  logic [55:0] out_data_next;

  // input field slices
  logic [gda_pkg::DAY_W-1:0]   in_d1, in_d2;
  logic [gda_pkg::MONTH_W-1:0] in_m1, in_m2;
  logic [gda_pkg::YEAR_W-1:0]  in_y1, in_y2;
  logic                        in_before, in_equal;

  assign in_d1 = s_axis_tdata[6:2];
  assign in_m1 = s_axis_tdata[10:7];
  assign in_y1 = s_axis_tdata[24:11];
  assign in_d2 = s_axis_tdata[29:25];
  assign in_m2 = s_axis_tdata[33:30];
  assign in_y2 = s_axis_tdata[47:34];

  always_comb begin
    if (in_y1 != in_y2) begin
      in_before = in_y1 < in_y2;
    end else if (in_m1 != in_m2) begin
      in_before = in_m1 < in_m2;
    end else begin
      in_before = in_d1 < in_d2;
    end
  end
  assign in_equal = (in_y1 == in_y2) && (in_m1 == in_m2) && (in_d1 == in_d2);

  // date under conversion
  logic [gda_pkg::DAY_W-1:0]   cur_d;
  logic [gda_pkg::MONTH_W-1:0] cur_m;
  logic [gda_pkg::YEAR_W-1:0]  cur_y;

  assign cur_d = which ? d2 : d1;
  assign cur_m = which ? m2 : m1;
  assign cur_y = which ? y2 : y1;

  logic cur_ok;
  assign cur_ok = (cur_y != '0) && (cur_y <= gda_pkg::YEAR_MAX) &&
                  (cur_m != '0) && (cur_m <= 4'd12) && (cur_d != '0) &&
                  (cur_d <= gda_pkg::month_len(cur_m, 1'b1));

  // shared step unit
  logic [gda_pkg::CHUNK_YW-1:0] chunk_y;
  logic [gda_pkg::CHUNK_DW-1:0] chunk_d;
  logic                         cnt_ok, to_take, from_take, leap;
  logic [gda_pkg::DAY_W-1:0]    mlen;
  logic                         feb_bad, to_more, from_more;

  assign chunk_y = gda_pkg::chunk_years(phase);
  assign chunk_d = gda_pkg::chunk_days(phase);
  // the last century of a cycle and the last year of a 4-year block stay partial
  assign cnt_ok  = (phase == 2'd1) ? (nb != 2'd3) :
                   (phase == 2'd3) ? (nd != 2'd3) : 1'b1;
  assign to_take   = yrs >= gda_pkg::YEAR_W'(chunk_y);
  assign from_take = (days >= gda_pkg::SERIAL_W'(chunk_d)) && cnt_ok;
  // year is leap when it closes a 4-year block that is not a plain century end
  assign leap      = (nd == 2'd3) && ((nc != 5'd24) || (nb == 2'd3));
  assign mlen      = gda_pkg::month_len(k, leap);
  assign feb_bad   = (cur_m == 4'd2) && (cur_d == 5'd29) && !leap;
  assign to_more   = k < cur_m;
  assign from_more = (k < 4'd12) && (days >= gda_pkg::SERIAL_W'(mlen));

  logic [SUM_W-1:0] s1_ext, count_ext, off_add, off_sub;
  logic             off_sat, off_under;

  assign s1_ext    = SUM_W'(s1);
  assign count_ext = SUM_W'(count);
  assign off_add   = s1_ext + count_ext;
  assign off_sub   = s1_ext - count_ext;
  assign off_sat   = off_add > SUM_W'(gda_pkg::SERIAL_MAX);
  assign off_under = count_ext > s1_ext;

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == gda_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gda_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = gda_pkg::ST_CHECK;
        end
      end
      gda_pkg::ST_CHECK: begin
        if (func == gda_pkg::FUNC_NONE || !cur_ok) begin
          state_next = gda_pkg::ST_OUT;
        end else begin
          state_next = gda_pkg::ST_TO_YEARS;
        end
      end
      gda_pkg::ST_TO_YEARS: begin
        if (!to_take && phase == 2'd3) begin
          state_next = feb_bad ? gda_pkg::ST_OUT : gda_pkg::ST_TO_MONTHS;
        end
      end
      gda_pkg::ST_TO_MONTHS: begin
        if (!to_more) begin
          state_next = gda_pkg::ST_TO_DONE;
        end
      end
      gda_pkg::ST_TO_DONE: begin
        if (which) begin
          state_next = gda_pkg::ST_OUT;
        end else if (func == gda_pkg::FUNC_DIFF) begin
          state_next = gda_pkg::ST_CHECK;
        end else begin
          state_next = gda_pkg::ST_OFFSET;
        end
      end
      gda_pkg::ST_OFFSET: begin
        state_next = gda_pkg::ST_FROM_YEARS;
      end
      gda_pkg::ST_FROM_YEARS: begin
        if (!from_take && phase == 2'd3) begin
          state_next = gda_pkg::ST_FROM_MONTHS;
        end
      end
      gda_pkg::ST_FROM_MONTHS: begin
        if (!from_more) begin
          state_next = gda_pkg::ST_OUT;
        end
      end
      gda_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = gda_pkg::ST_IDLE;
        end
      end
      default: state_next = gda_pkg::ST_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    func_next   = func;
    d1_next     = d1;
    m1_next     = m1;
    y1_next     = y1;
    d2_next     = d2;
    m2_next     = m2;
    y2_next     = y2;
    count_next  = count;
    earlier_next = earlier;
    equal_next  = equal;
    which_next  = which;
    yrs_next    = yrs;
    days_next   = days;
    s1_next     = s1;
    phase_next  = phase;
    nb_next     = nb;
    nc_next     = nc;
    nd_next     = nd;
    k_next      = k;
    res_d_next  = res_d;
    res_m_next  = res_m;
    res_y_next  = res_y;
    diff_next   = diff;
    err_next    = err;
    out_valid_next = m_axis_tvalid && !m_axis_tready;
    out_data_next  = m_axis_tdata;

    case (state)
      gda_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          func_next   = gda_pkg::func_t'(s_axis_tdata[1:0]);
          d1_next     = in_d1;
          m1_next     = in_m1;
          y1_next     = in_y1;
          d2_next     = in_d2;
          m2_next     = in_m2;
          y2_next     = in_y2;
          count_next  = s_axis_tdata[48 +: COUNT_BITS];
          earlier_next = in_before;
          equal_next  = in_equal;
          which_next  = 1'b0;
          res_d_next  = '0;
          res_m_next  = '0;
          res_y_next  = '0;
          diff_next   = '0;
          err_next    = 1'b0;
        end
      end
      gda_pkg::ST_CHECK: begin
        if (func == gda_pkg::FUNC_NONE || !cur_ok) begin
          err_next = 1'b1;
        end else begin
          yrs_next   = cur_y - 14'd1;
          days_next  = '0;
          phase_next = 2'd0;
          nb_next    = '0;
          nc_next    = '0;
          nd_next    = '0;
        end
      end
      gda_pkg::ST_TO_YEARS: begin
        if (to_take) begin
          yrs_next  = yrs - gda_pkg::YEAR_W'(chunk_y);
          days_next = days + gda_pkg::SERIAL_W'(chunk_d);
          case (phase)
            2'd1:    nb_next = nb + 2'd1;
            2'd2:    nc_next = nc + 5'd1;
            2'd3:    nd_next = nd + 2'd1;
            default: ;
          endcase
        end else if (phase == 2'd3) begin
          k_next = 4'd1;
          if (feb_bad) begin
            err_next = 1'b1;
          end
        end else begin
          phase_next = phase + 2'd1;
        end
      end
      gda_pkg::ST_TO_MONTHS: begin
        if (to_more) begin
          days_next = days + gda_pkg::SERIAL_W'(mlen);
          k_next    = k + 4'd1;
        end else begin
          days_next = days + gda_pkg::SERIAL_W'(cur_d) - 22'd1;
        end
      end
      gda_pkg::ST_TO_DONE: begin
        if (which) begin
          diff_next  = {1'b0, s1} - {1'b0, days};
          res_d_next = d1;
          res_m_next = m1;
          res_y_next = y1;
        end else begin
          s1_next = days;
          if (func == gda_pkg::FUNC_DIFF) begin
            which_next = 1'b1;
          end
        end
      end
      gda_pkg::ST_OFFSET: begin
        if (func == gda_pkg::FUNC_ADD) begin
          days_next = off_sat ? gda_pkg::SERIAL_MAX : off_add[gda_pkg::SERIAL_W-1:0];
          err_next  = off_sat;
        end else begin
          days_next = off_under ? '0 : off_sub[gda_pkg::SERIAL_W-1:0];
          err_next  = off_under;
        end
        yrs_next   = '0;
        phase_next = 2'd0;
        nb_next    = '0;
        nc_next    = '0;
        nd_next    = '0;
      end
      gda_pkg::ST_FROM_YEARS: begin
        if (from_take) begin
          days_next = days - gda_pkg::SERIAL_W'(chunk_d);
          yrs_next  = yrs + gda_pkg::YEAR_W'(chunk_y);
          case (phase)
            2'd1:    nb_next = nb + 2'd1;
            2'd2:    nc_next = nc + 5'd1;
            2'd3:    nd_next = nd + 2'd1;
            default: ;
          endcase
        end else if (phase == 2'd3) begin
          k_next = 4'd1;
        end else begin
          phase_next = phase + 2'd1;
        end
      end
      gda_pkg::ST_FROM_MONTHS: begin
        if (from_more) begin
          days_next = days - gda_pkg::SERIAL_W'(mlen);
          k_next    = k + 4'd1;
        end else begin
          res_d_next = days[gda_pkg::DAY_W-1:0] + 5'd1;
          res_m_next = k;
          res_y_next = yrs + 14'd1;
        end
      end
      gda_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = {6'd0, err, !earlier && !equal, equal, earlier,
                            diff, res_y, res_m, res_d};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gda_pkg::ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      m_axis_tvalid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    func         <= func_next;
    d1           <= d1_next;
    m1           <= m1_next;
    y1           <= y1_next;
    d2           <= d2_next;
    m2           <= m2_next;
    y2           <= y2_next;
    count        <= count_next;
    earlier      <= earlier_next;
    equal        <= equal_next;
    which        <= which_next;
    yrs          <= yrs_next;
    days         <= days_next;
    s1           <= s1_next;
    phase        <= phase_next;
    nb           <= nb_next;
    nc           <= nc_next;
    nd           <= nd_next;
    k            <= k_next;
    res_d        <= res_d_next;
    res_m        <= res_m_next;
    res_y        <= res_y_next;
    diff         <= diff_next;
    err          <= err_next;
    m_axis_tdata <= out_data_next;
  end

endmodule
